@@ rtl/core/bfc_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and layout helpers for the buddy free coalescer
package bfc_pkg;

    localparam int ADDR_UNITS_DEF = 1024;
    localparam int LEVELS_DEF     = 9;

    localparam int START_W = 10;
    localparam int LEVEL_W = 4;
    localparam int STAT_W  = 2;

    // free map is stored as rows of ROW_W bits, each level starting on a new row
    localparam int ROW_W  = 32;
    localparam int ROW_AW = 5;

    localparam logic OP_FREE = 1'b0;
    localparam logic OP_TAKE = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_DUP   = 2'd3;

    typedef struct packed {
        logic               opcode;
        logic [START_W-1:0] block_start;
        logic [LEVEL_W-1:0] block_level;
    } bfc_in_t;

    typedef struct packed {
        logic [START_W-1:0] result_start;
        logic [LEVEL_W-1:0] result_level;
        logic [STAT_W-1:0]  status;
    } bfc_out_t;

    typedef enum logic [2:0] {
        RES_FREE,
        RES_TAKE,
        RES_EMPTY,
        RES_BAD,
        RES_DUP
    } bfc_res_kind_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_FSCAN,
        S_FWAIT,
        S_FDEC,
        S_FWRITE,
        S_TSCAN,
        S_TCLR,
        S_DONE
    } bfc_state_t;

    typedef struct packed {
        logic          load;
        logic          clr_wr;
        logic          rd_free;
        logic          wr_init;
        logic          free_wr;
        logic          rd_take;
        logic          take_wr;
        logic          res_load;
        bfc_res_kind_t res_kind;
        logic          out_load;
    } bfc_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic op_take;
        logic bad_free;
        logic bad_take;
        logic scan_last;
        logic dup;
        logic wr_last;
        logic take_hit;
        logic take_pend;
        logic take_done;
        logic out_busy;
    } bfc_stat_t;

    // rows used by one level's bitmap
    function automatic int level_rows(input int units, input int lvl);
        return ((units >> lvl) + ROW_W - 1) >> ROW_AW;
    endfunction

    // first row of a level; with lvl equal to the level count it gives the total
    function automatic int level_base_row(input int units, input int lvl);
        int acc;
        acc = 0;
        for (int k = 0; k < lvl; k++) begin
            acc += level_rows(units, k);
        end
        return acc;
    endfunction

endpackage

@@ rtl/core/bfc_ctrl.sv @@
`timescale 1ns / 1ps
// sequencer for clear, free-with-merge and take operations
module bfc_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output bfc_pkg::bfc_cmd_t  cmd,
    input  bfc_pkg::bfc_stat_t stat
);
    import bfc_pkg::*;

    bfc_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_kind = RES_FREE;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (stat.op_take) begin
                    if (stat.bad_take) begin
                        cmd.res_load = 1'b1;
                        cmd.res_kind = RES_EMPTY;
                        state_next   = S_DONE;
                    end else begin
                        state_next = S_TSCAN;
                    end
                end else if (stat.bad_free) begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = RES_BAD;
                    state_next   = S_DONE;
                end else begin
                    state_next = S_FSCAN;
                end
            end
            S_FSCAN: begin
                cmd.rd_free = 1'b1;
                if (stat.scan_last) begin
                    state_next = S_FWAIT;
                end
            end
            S_FWAIT: begin
                state_next = S_FDEC;
            end
            S_FDEC: begin
                if (stat.dup) begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = RES_DUP;
                    state_next   = S_DONE;
                end else begin
                    cmd.wr_init = 1'b1;
                    state_next  = S_FWRITE;
                end
            end
            S_FWRITE: begin
                cmd.free_wr = 1'b1;
                if (stat.wr_last) begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = RES_FREE;
                    state_next   = S_DONE;
                end
            end
            S_TSCAN: begin
                priority if (stat.take_hit) begin
                    state_next = S_TCLR;
                end else if (stat.take_done && !stat.take_pend) begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = RES_EMPTY;
                    state_next   = S_DONE;
                end else if (!stat.take_done) begin
                    cmd.rd_take = 1'b1;
                end else begin
                    state_next = S_TSCAN;
                end
            end
            S_TCLR: begin
                cmd.take_wr  = 1'b1;
                cmd.res_load = 1'b1;
                cmd.res_kind = RES_TAKE;
                state_next   = S_DONE;
            end
            S_DONE: begin
                if (!stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

@@ rtl/core/bfc_dpath.sv @@
`timescale 1ns / 1ps
// free-map memory, operand registers, scan counters and result registers
module bfc_dpath #(
    parameter int ADDR_UNITS = bfc_pkg::ADDR_UNITS_DEF,
    parameter int LEVELS     = bfc_pkg::LEVELS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  bfc_pkg::bfc_in_t    s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output bfc_pkg::bfc_out_t   m_data,
    input  bfc_pkg::bfc_cmd_t   cmd,
    output bfc_pkg::bfc_stat_t  stat
);
    import bfc_pkg::*;

    localparam int TOTAL_ROWS = level_base_row(ADDR_UNITS, LEVELS);
    localparam int MAX_ROWS   = level_rows(ADDR_UNITS, 0);
    localparam int RAW        = (TOTAL_ROWS > 1) ? $clog2(TOTAL_ROWS) : 1;
    localparam int RCW        = $clog2(MAX_ROWS + 1);
    localparam int CW         = $clog2(ADDR_UNITS + 1);
    localparam int UW         = (CW > START_W) ? CW : START_W;
    localparam int LIW        = $clog2(LEVELS);
    localparam int TW         = (RCW + ROW_AW > START_W) ? RCW + ROW_AW : START_W;

    // per-level layout constants
    logic [RAW-1:0] base_tab [LEVELS];
    logic [RCW-1:0] rows_tab [LEVELS];
    logic [CW-1:0]  cnt_tab  [LEVELS];

    for (genvar g = 0; g < LEVELS; g++) begin : g_tab
        assign base_tab[g] = RAW'(level_base_row(ADDR_UNITS, g));
        assign rows_tab[g] = RCW'(level_rows(ADDR_UNITS, g));
        assign cnt_tab[g]  = CW'(ADDR_UNITS >> g);
    end

    logic [ROW_W-1:0] mem [TOTAL_ROWS];

    bfc_in_t          in_reg;
    logic [LIW-1:0]   lvl_cnt_reg;
    logic [LIW-1:0]   top_reg;
    logic             dup_reg;
    logic             merge_reg;
    logic [RCW-1:0]   row_cnt_reg;
    logic [RCW-1:0]   rd_roff_reg;
    logic [RCW-1:0]   take_row_reg;
    logic [ROW_AW-1:0] rd_pos_reg;
    logic [ROW_AW-1:0] take_pos_reg;
    logic             rd_afit_reg;
    logic             rd_bfit_reg;
    logic             rd_free_v_reg;
    logic             rd_take_v_reg;
    logic [ROW_W-1:0] rd_data_reg;
    logic [RAW-1:0]   clr_cnt_reg;
    bfc_out_t         res_reg;
    bfc_out_t         out_reg;
    logic             out_valid_reg;

    function automatic logic [ROW_AW-1:0] low_one(input logic [ROW_W-1:0] w);
        logic [ROW_AW-1:0] p;
        p = '0;
        for (int b = ROW_W - 1; b >= 0; b--) begin
            if (w[b]) p = ROW_AW'(b);
        end
        return p;
    endfunction

    // operand checks
    logic [LIW-1:0]     in_lvl;
    logic [START_W-1:0] in_idx;
    logic               lvl_ok;
    logic               aligned;
    logic               fit0;

    assign in_lvl  = in_reg.block_level[LIW-1:0];
    assign in_idx  = in_reg.block_start >> in_reg.block_level;
    assign lvl_ok  = (5'(in_reg.block_level) < 5'(LEVELS));
    assign aligned = ((in_reg.block_start >> in_reg.block_level) << in_reg.block_level)
                     == in_reg.block_start;
    assign fit0    = (UW'(in_idx) < UW'(cnt_tab[in_lvl]));

    // ancestor at the scan level, its buddy shares the row
    logic [START_W-1:0] f_idx;
    logic [START_W-1:0] f_bidx;
    logic [RAW-1:0]     f_row;
    logic [ROW_AW-1:0]  f_pos;
    logic               f_afit;
    logic               f_bfit;
    logic               wr_last;
    logic               scan_last;

    assign f_idx     = in_reg.block_start >> lvl_cnt_reg;
    assign f_bidx    = f_idx ^ START_W'(1);
    assign f_row     = base_tab[lvl_cnt_reg] + RAW'(f_idx >> ROW_AW);
    assign f_pos     = f_idx[ROW_AW-1:0];
    assign f_afit    = (UW'(f_idx) < UW'(cnt_tab[lvl_cnt_reg]));
    assign f_bfit    = (UW'(f_bidx) < UW'(cnt_tab[lvl_cnt_reg]));
    assign wr_last   = (lvl_cnt_reg == top_reg);
    assign scan_last = (lvl_cnt_reg == LIW'(LEVELS - 1));

    logic anc_bit;
    logic bud_bit;
    logic take_hit;

    assign anc_bit  = rd_data_reg[rd_pos_reg] & rd_afit_reg;
    assign bud_bit  = rd_data_reg[rd_pos_reg ^ ROW_AW'(1)] & rd_bfit_reg;
    assign take_hit = rd_take_v_reg && (rd_data_reg != '0);

    // memory ports
    logic             wr_en;
    logic [RAW-1:0]   wr_addr;
    logic [ROW_W-1:0] wr_mask;
    logic             wr_bit;
    logic             rd_en;
    logic [RAW-1:0]   rd_addr;

    always_comb begin
        wr_en   = cmd.clr_wr | cmd.free_wr | cmd.take_wr;
        wr_addr = clr_cnt_reg;
        wr_mask = '1;
        wr_bit  = 1'b0;
        priority if (cmd.free_wr) begin
            wr_addr = f_row;
            wr_mask = '0;
            wr_mask[wr_last ? f_pos : (f_pos ^ ROW_AW'(1))] = 1'b1;
            // buddies below the resting level are cleared, the merged block is set
            wr_bit  = wr_last;
        end else if (cmd.take_wr) begin
            wr_addr = base_tab[in_lvl] + RAW'(take_row_reg);
            wr_mask = '0;
            wr_mask[take_pos_reg] = 1'b1;
        end else begin
            wr_addr = clr_cnt_reg;
        end
        rd_en   = cmd.rd_free | cmd.rd_take;
        rd_addr = cmd.rd_take ? (base_tab[in_lvl] + RAW'(row_cnt_reg)) : f_row;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            for (int b = 0; b < ROW_W; b++) begin
                if (wr_mask[b]) mem[wr_addr][b] <= wr_bit;
            end
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // result formation
    bfc_out_t res_next;

    always_comb begin
        res_next.result_start = in_reg.block_start;
        res_next.result_level = in_reg.block_level;
        res_next.status       = STAT_OK;
        unique case (cmd.res_kind)
            RES_FREE: begin
                res_next.result_start = (in_reg.block_start >> top_reg) << top_reg;
                res_next.result_level = LEVEL_W'(top_reg);
            end
            RES_TAKE: begin
                res_next.result_start =
                    START_W'(TW'({take_row_reg, take_pos_reg}) << in_reg.block_level);
            end
            RES_EMPTY: begin
                res_next.result_start = '0;
                res_next.status       = STAT_EMPTY;
            end
            RES_BAD: begin
                res_next.status = STAT_BAD;
            end
            RES_DUP: begin
                res_next.status = STAT_DUP;
            end
            default: begin
                res_next.status = STAT_OK;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg   <= '0;
            rd_free_v_reg <= 1'b0;
            rd_take_v_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.clr_wr) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            rd_free_v_reg <= cmd.rd_free;
            rd_take_v_reg <= cmd.rd_take;
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            in_reg      <= s_data;
            lvl_cnt_reg <= s_data.block_level[LIW-1:0];
            top_reg     <= s_data.block_level[LIW-1:0];
            dup_reg     <= 1'b0;
            merge_reg   <= 1'b1;
            row_cnt_reg <= '0;
        end
        if (cmd.rd_free) begin
            if (!scan_last) lvl_cnt_reg <= lvl_cnt_reg + 1'b1;
            rd_pos_reg  <= f_pos;
            rd_afit_reg <= f_afit;
            rd_bfit_reg <= f_bfit;
        end
        if (cmd.wr_init) begin
            lvl_cnt_reg <= in_lvl;
        end
        if (cmd.free_wr && !wr_last) begin
            lvl_cnt_reg <= lvl_cnt_reg + 1'b1;
        end
        // levels arrive in order, so the merge front follows the read stream
        if (rd_free_v_reg) begin
            dup_reg <= dup_reg | anc_bit;
            if (merge_reg && bud_bit && (top_reg != LIW'(LEVELS - 1))) begin
                top_reg <= top_reg + 1'b1;
            end else begin
                merge_reg <= 1'b0;
            end
        end
        if (cmd.rd_take) begin
            row_cnt_reg <= row_cnt_reg + 1'b1;
            rd_roff_reg <= row_cnt_reg;
        end
        if (take_hit) begin
            take_row_reg <= rd_roff_reg;
            take_pos_reg <= low_one(rd_data_reg);
        end
        if (cmd.res_load) begin
            res_reg <= res_next;
        end
        if (cmd.out_load) begin
            out_reg <= res_reg;
        end
    end

    assign stat.clr_last  = (clr_cnt_reg == RAW'(TOTAL_ROWS - 1));
    assign stat.op_take   = (in_reg.opcode == OP_TAKE);
    assign stat.bad_free  = !lvl_ok || !aligned || !fit0;
    assign stat.bad_take  = !lvl_ok || (rows_tab[in_lvl] == '0);
    assign stat.scan_last = scan_last;
    assign stat.dup       = dup_reg;
    assign stat.wr_last   = wr_last;
    assign stat.take_hit  = take_hit;
    assign stat.take_pend = rd_take_v_reg;
    assign stat.take_done = (row_cnt_reg == rows_tab[in_lvl]);
    assign stat.out_busy  = out_valid_reg && !m_ready;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

@@ rtl/core/buddy_free_coalesce.sv @@
`timescale 1ns / 1ps
// top level of the buddy free-list coalescer
//
// Input channel s_valid/s_ready/s_data carries one operation per beat: a free of
// block_start at block_level (merged with free buddies as far as possible) or a
// take of the lowest free block of block_level. Every beat yields exactly one
// result beat on m_valid/m_ready/m_data with the resting or taken block and a status.
// One operation is in flight at a time; s_ready is high only while idle.
// Free: after the check step the free map is read one row per level from block_level
// to the top level; after a wait and a decision step one bit is written per level
// up to the resting level. Take: the rows of the level's bitmap, 32 bits each, are read
// in order until one holds a free block, whose lowest one is then cleared; an empty
// take reads every row of its level. Bad or misaligned frees, and bad takes, end at
// the check step. s_ready returns in the cycle after the result is loaded into the
// output register. After reset the free-map memory is swept to zero one row per cycle,
// over the sum across levels of ceil((ADDR_UNITS >> level) / 32) rows;
// s_ready stays low until the sweep ends.
// The result sits in an output register; a stalled receiver holds it while the
// next operation is accepted and worked on, which then waits until the register frees.
module buddy_free_coalesce #(
    parameter int ADDR_UNITS = bfc_pkg::ADDR_UNITS_DEF,
    parameter int LEVELS     = bfc_pkg::LEVELS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  bfc_pkg::bfc_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output bfc_pkg::bfc_out_t m_data
);
    import bfc_pkg::*;

    bfc_cmd_t  cmd;
    bfc_stat_t stat;

    bfc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    bfc_dpath #(
        .ADDR_UNITS (ADDR_UNITS),
        .LEVELS     (LEVELS)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .stat    (stat)
    );

endmodule

@@ rtl/core/bfc_checker.sv @@
`timescale 1ns / 1ps
// port-level checks for the buddy free coalescer, bound to the top level
module bfc_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input bfc_pkg::bfc_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input bfc_pkg::bfc_out_t m_data
);
    import bfc_pkg::*;

    // reset starts the clearing sweep with nothing offered on either side
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("ready or result valid right after reset");

    // one operation at a time
    a_single_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second beat taken while an operation is in flight");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == STAT_EMPTY) |-> (m_data.result_start == '0))
        else $error("empty take with nonzero start");

    // a freed or taken block always starts on a multiple of its size
    a_ok_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == STAT_OK) |->
        (((m_data.result_start >> m_data.result_level) << m_data.result_level)
            == m_data.result_start))
        else $error("successful result not aligned to its level");

endmodule

bind buddy_free_coalesce bfc_checker u_bfc_checker (.*);
